### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk and are quiet
// while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/dwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dwc_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int TAPS           = 9;

	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_PAD_ROWS_TOP  = 3'd2;
	localparam logic [2:0] REG_PAD_COLS_LEFT = 3'd3;
	localparam logic [2:0] REG_STRIDE_TWO    = 3'd4;
	localparam logic [2:0] REG_RESULT_WIDTH  = 3'd5;
	localparam logic [2:0] REG_RESULT_HEIGHT = 3'd6;

	localparam logic FUNC_COEF  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	typedef logic signed [15:0] word_t;

	typedef struct packed {
		logic              func;
		logic [3:0]        coef_index;
		logic signed [15:0] coef_value;
		logic signed [15:0] pixel;
	} item_t;

	typedef struct packed {
		logic signed [34:0] window_sum;
		logic [9:0]         out_row;
		logic [9:0]         out_col;
		logic               last;
	} result_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic bank;
	} mem_req_t;

	typedef struct packed {
		logic start;
		logic take;
	} mac_ctl_t;

	typedef struct packed {
		logic running;
		logic done;
	} mac_stat_t;

	// A dimension register of zero counts as one; above the limit it is the limit.
	function automatic logic [10:0] clamp_dim(input logic [10:0] v, input int hi);
		if (v == 11'd0) begin
			return 11'd1;
		end
		if ({21'd0, v} > 32'(hi)) begin
			return 11'(hi);
		end
		return v;
	endfunction

	function automatic logic [1:0] clamp_pad(input logic [1:0] p);
		return (p == 2'd3) ? 2'd2 : p;
	endfunction

	// True when the window whose last in-image pixel along this axis sits at p,
	// with the window offset t, starts on a stride point below the limit.
	function automatic logic org_ok(input logic [15:0] p, input logic p_last,
			input logic [1:0] t, input logic [1:0] pad, input logic s2,
			input logic [15:0] lim);
		logic [17:0] q;
		logic [16:0] id;
		q = 18'(p) + 18'(t) + 18'(pad) - 18'd2;
		id = s2 ? q[17:1] : q[16:0];
		return (t == 2'd0 || p_last) && !q[17] && (!s2 || !q[0]) && (id < {1'b0, lim});
	endfunction

	function automatic logic [9:0] org_idx(input logic [15:0] p, input logic [1:0] t,
			input logic [1:0] pad, input logic s2);
		logic [17:0] q;
		q = 18'(p) + 18'(t) + 18'(pad) - 18'd2;
		return s2 ? q[10:1] : q[9:0];
	endfunction

	function automatic logic [1:0] first_set(input logic [2:0] m);
		return m[0] ? 2'd0 : (m[1] ? 2'd1 : 2'd2);
	endfunction

	// Returns {found, index} of the lowest set bit above position t.
	function automatic logic [2:0] next_set(input logic [2:0] m, input logic [1:0] t);
		logic [2:0] hi;
		case (t)
			2'd0: hi = m & 3'b110;
			2'd1: hi = m & 3'b100;
			default: hi = 3'b000;
		endcase
		return {|hi, first_set(hi)};
	endfunction

endpackage

`default_nettype wire

### hdl/dwc_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Two line banks, one per row parity, read together at one column address.
module dwc_line_mem import dwc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  mem_req_t      req,
	input  logic [AW-1:0] addr,
	input  word_t         wdata,
	output word_t         rdata0,
	output word_t         rdata1
);

	word_t bank0 [MAX_WIDTH];
	word_t bank1 [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata0 <= bank0[addr];
			rdata1 <= bank1[addr];
		end
		if (req.wr && !req.bank) begin
			bank0[addr] <= wdata;
		end
		if (req.wr && req.bank) begin
			bank1[addr] <= wdata;
		end
	end

endmodule

`default_nettype wire

### hdl/dwc_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// One multiply-accumulate unit that walks the nine taps, one per cycle.
module dwc_mac import dwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctl_t           ctl,
	input  word_t              coef [TAPS],
	input  word_t              opnd [TAPS],
	output mac_stat_t          stat,
	output logic signed [34:0] sum
);

	localparam logic [3:0] LAST_TAP = 4'(TAPS);

	logic [3:0]         tap_q;
	logic               run_q;
	logic signed [31:0] prod_q;
	logic signed [34:0] acc_q;

	assign stat.running = run_q;
	assign stat.done    = run_q && (tap_q == LAST_TAP);
	assign sum          = acc_q + 35'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			run_q <= 1'b0;
		end else if (ctl.start) begin
			tap_q <= '0;
			run_q <= 1'b1;
		end else if (run_q && tap_q != LAST_TAP) begin
			tap_q <= tap_q + 4'd1;
		end else if (stat.done && ctl.take) begin
			run_q <= 1'b0;
		end
	end

	// The product is registered; it joins the sum in the cycle after.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
		end else if (run_q && tap_q != LAST_TAP) begin
			prod_q <= 32'(coef[tap_q]) * 32'(opnd[tap_q]);
			if (tap_q != 4'd0) begin
				acc_q <= acc_q + 35'(prod_q);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/depthwise_conv3x3_padded.sv
// Depthwise 3x3 convolution of one channel plane with stride one or two and zero
// padding above and to the left. Items on the input channel either load one
// filter coefficient or deliver the next pixel in raster order. A pixel takes
// the line-bank read, then the window update and write-back, then one sum for
// each result it completes, since a single multiply-accumulate unit walks the
// nine taps and then hands the sum to the output register; a pixel completes
// between zero and nine results, and a new item is accepted only once the block
// is idle again. The results of one pixel are emitted in raster order of output
// position, the final one marked with last, and a waiting result in the output
// register does not stop the next computation until the next sum is ready. A
// write to any configuration register restarts the plane at row zero, column
// zero; the user must write configuration only while the block is idle, and the
// block does not enforce it. Coefficients and the window reset to zero; the line
// banks need no clearing since taps outside the image are masked by position.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module depthwise_conv3x3_padded import dwc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT);

	// Item sequencer: wait for a transaction, take the bank data, run the sums.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_MAC  = 2'd2;

	logic [1:0]  state_q;

	// Configuration registers, held raw and clamped where they are used.
	logic [10:0] img_w_q, img_h_q, res_w_q, res_h_q;
	logic [1:0]  pad_t_q, pad_l_q;
	logic        s2_q;

	logic [10:0] dim_w, dim_h, lim_w, lim_h;
	logic [1:0]  pad_t, pad_l;

	// Raster position of the pixel being processed.
	logic [RB-1:0] row_q;
	logic [CW-1:0] col_q;
	word_t         pix_q;

	word_t coef_q [TAPS];
	word_t win_q  [TAPS];
	word_t opnd   [TAPS];

	// Window origins that complete at this pixel, one mask per axis, and the
	// origin pair whose sum is being built.
	logic [2:0] vr_d, vc_d, vr_q, vc_q;
	logic [1:0] tr_q, tc_q;
	logic       row_last, col_last;
	logic       any_d;
	logic [2:0] nxt_c, nxt_r;
	logic       more;

	logic      cfg_fire, cfg_hit, in_fire, out_free, take, finish;
	mem_req_t  mem_req;
	word_t     rd0, rd1, rd_cur, rd_prev;
	mac_ctl_t  mac_ctl;
	mac_stat_t mac_stat;
	logic signed [34:0] mac_sum;

	logic    ov_q;
	result_t out_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	// Only a write that lands on a real register restarts the plane.
	assign cfg_hit   = cfg_fire && (cfg_index <= REG_RESULT_HEIGHT);
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = ov_q;
	assign out_data  = out_q;

	assign dim_w = clamp_dim(img_w_q, MAX_WIDTH);
	assign dim_h = clamp_dim(img_h_q, MAX_HEIGHT);
	assign lim_w = clamp_dim(res_w_q, MAX_WIDTH);
	assign lim_h = clamp_dim(res_h_q, MAX_HEIGHT);
	assign pad_t = clamp_pad(pad_t_q);
	assign pad_l = clamp_pad(pad_l_q);

	assign row_last = (16'(row_q) == 16'(dim_h) - 16'd1);
	assign col_last = (16'(col_q) == 16'(dim_w) - 16'd1);

	always_comb begin
		for (int t = 0; t < 3; t++) begin
			vr_d[t] = org_ok(16'(row_q), row_last, 2'(t), pad_t, s2_q, 16'(lim_h));
			vc_d[t] = org_ok(16'(col_q), col_last, 2'(t), pad_l, s2_q, 16'(lim_w));
		end
	end

	assign any_d = (|vr_d) && (|vc_d);

	// Pairs go in raster order: across the column origins, then the next row.
	assign nxt_c = next_set(vc_q, tc_q);
	assign nxt_r = next_set(vr_q, tr_q);
	assign more  = nxt_c[2] || nxt_r[2];

	assign out_free = !ov_q || out_ready;
	assign take     = mac_stat.done && out_free;
	assign finish   = (state_q == ST_LOAD && !any_d) || (take && !more);

	assign mac_ctl.start = (state_q == ST_LOAD && any_d) || (take && more);
	assign mac_ctl.take  = take;

	// The bank of the current row parity holds the row two above; the other
	// bank holds the row just above.
	assign rd_cur  = row_q[0] ? rd1 : rd0;
	assign rd_prev = row_q[0] ? rd0 : rd1;

	assign mem_req.rd   = in_fire && (in_data.func == FUNC_PIXEL);
	assign mem_req.wr   = (state_q == ST_LOAD);
	assign mem_req.bank = row_q[0];

	dwc_line_mem #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_mem (
		.clk    (clk),
		.req    (mem_req),
		.addr   (col_q),
		.wdata  (pix_q),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	// Align the window to the current origin pair. A tap counts only when it
	// lies inside the window and inside the image; stale taps read as zero.
	always_comb begin
		word_t sel;
		logic  row_ok, col_ok;
		for (int k = 0; k < TAPS; k++) begin
			sel = '0;
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					if (tr_q == 2'(a) && tc_q == 2'(b) && (k / 3 + a) <= 2
							&& (k % 3 + b) <= 2) begin
						sel = win_q[((k / 3 + a) <= 2 && (k % 3 + b) <= 2)
							? (k / 3 + a) * 3 + k % 3 + b : 0];
					end
				end
			end
			row_ok = (13'(row_q) + 13'(k / 3) + 13'(tr_q)) >= 13'd2;
			col_ok = (13'(col_q) + 13'(k % 3) + 13'(tc_q)) >= 13'd2;
			opnd[k] = (row_ok && col_ok) ? sel : '0;
		end
	end

	dwc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_q),
		.opnd   (opnd),
		.stat   (mac_stat),
		.sum    (mac_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 11'd16;
			img_h_q <= 11'd16;
			pad_t_q <= 2'd1;
			pad_l_q <= 2'd1;
			s2_q    <= 1'b0;
			res_w_q <= 11'd16;
			res_h_q <= 11'd16;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   img_w_q <= cfg_data;
				REG_IMAGE_HEIGHT:  img_h_q <= cfg_data;
				REG_PAD_ROWS_TOP:  pad_t_q <= cfg_data[1:0];
				REG_PAD_COLS_LEFT: pad_l_q <= cfg_data[1:0];
				REG_STRIDE_TWO:    s2_q    <= cfg_data[0];
				REG_RESULT_WIDTH:  res_w_q <= cfg_data;
				REG_RESULT_HEIGHT: res_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			vr_q    <= '0;
			vc_q    <= '0;
			tr_q    <= '0;
			tc_q    <= '0;
			ov_q    <= 1'b0;
			for (int k = 0; k < TAPS; k++) begin
				coef_q[k] <= '0;
				win_q[k]  <= '0;
			end
		end else begin
			if (take) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire && in_data.func == FUNC_PIXEL) begin
						state_q <= ST_LOAD;
					end else if (in_fire && in_data.coef_index < 4'(TAPS)) begin
						coef_q[in_data.coef_index] <= in_data.coef_value;
					end
				end
				ST_LOAD: begin
					for (int k = 0; k < 3; k++) begin
						win_q[k * 3]     <= win_q[k * 3 + 1];
						win_q[k * 3 + 1] <= win_q[k * 3 + 2];
					end
					win_q[2] <= rd_cur;
					win_q[5] <= rd_prev;
					win_q[8] <= pix_q;
					vr_q     <= vr_d;
					vc_q     <= vc_d;
					tr_q     <= first_set(vr_d);
					tc_q     <= first_set(vc_d);
					state_q  <= any_d ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					if (take) begin
						if (nxt_c[2]) begin
							tc_q <= nxt_c[1:0];
						end else if (nxt_r[2]) begin
							tr_q <= nxt_r[1:0];
							tc_q <= first_set(vc_q);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// A configuration write to a real register starts a new plane.
			if (cfg_hit) begin
				row_q <= '0;
				col_q <= '0;
			end else if (finish) begin
				if ((13'(col_q) + 13'd1) >= 13'(dim_w)) begin
					col_q <= '0;
					row_q <= ((13'(row_q) + 13'd1) >= 13'(dim_h)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q <= in_data.pixel;
		end
		if (take) begin
			out_q.window_sum <= mac_sum;
			out_q.out_row    <= org_idx(16'(row_q), tr_q, pad_t, s2_q);
			out_q.out_col    <= org_idx(16'(col_q), tc_q, pad_l, s2_q);
			out_q.last       <= !more;
		end
	end

	`ASSERT_IMPLIES(a_done_in_mac, mac_stat.done, state_q == ST_MAC, "sum ready outside MAC")
	`ASSERT_IMPLIES(a_no_overwrite, take, !ov_q || out_ready, "result register overwritten")
	`ASSERT_NEXT(a_pixel_load, in_fire && in_data.func == FUNC_PIXEL, state_q == ST_LOAD,
		"pixel transaction did not reach LOAD")

endmodule

`default_nettype wire

### tb/sv/depthwise_conv3x3_padded_tb.sv
`timescale 1ns / 1ps

module depthwise_conv3x3_padded_tb;
	import dwc_pkg::*;

	// Register index with no register behind it; a write there must be ignored.
	localparam logic [2:0] REG_NONE = 3'd7;
	// Cycles without any transaction before the run is declared hung. A pixel may
	// keep the block busy through all nine of its sums, and each of its nine results
	// can then wait out a long receiver stall.
	localparam int HANG_LIMIT = 5000;
	// Quiet time after the last expected result. A coefficient load or a pixel that
	// completes no window may still be in flight at that point.
	localparam int DRAIN_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	item_t       in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	result_t     out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	// Idling percentages of the current phase for the sender and the receiver.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int failures = 0;
	int quiet_cycles = 0;

	// Mirror of the block: configuration, coefficients, line banks, window and the
	// raster position of the next pixel.
	int          reg_val [7];
	word_t       coef_mirror [TAPS];
	word_t       line_mirror [2 * DEF_MAX_WIDTH];
	word_t       win_mirror [9];
	int          cur_row;
	int          cur_col;
	result_t     pending_sums [$];

	depthwise_conv3x3_padded dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A dimension register of zero means one; anything above the limit is the limit.
	function automatic int eff_dim(input int v, input int hi);
		if (v < 1) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	// Lists the windows along one axis whose last in-image pixel sits at p. Only
	// the last pixel of an axis can close windows that hang over the far edge.
	function automatic int axis_windows(input int p, input int size, input int pad,
			input int s, input int lim, output int idx [3], output int org [3]);
		int n;
		int o;
		int q;
		n = 0;
		for (int t = 0; t < 3; t++) begin
			o = p - 2 + t;
			q = o + pad;
			if (t != 0 && p != size - 1) begin
				continue;
			end
			if (q < 0 || (q % s) != 0 || q / s >= lim) begin
				continue;
			end
			idx[n] = q / s;
			org[n] = o;
			n++;
		end
		return n;
	endfunction

	task automatic mirror_reset();
		reg_val = '{16, 16, 1, 1, 0, 16, 16};
		foreach (coef_mirror[i]) coef_mirror[i] = '0;
		foreach (line_mirror[i]) line_mirror[i] = '0;
		foreach (win_mirror[i]) win_mirror[i] = '0;
		cur_row = 0;
		cur_col = 0;
	endtask

	// Updates the mirror for one accepted item and queues the sums it completes.
	task automatic predict_sums(input item_t it);
		int w, h, pt, pl, s, rw, rh, r, c, cur, prv, nr, nc, y, x, wr, wc;
		int rows [3], rorg [3], cols [3], corg [3];
		longint acc;
		result_t res;
		int first;
		if (it.func == FUNC_COEF) begin
			if (it.coef_index < TAPS) begin
				coef_mirror[it.coef_index] = it.coef_value;
			end
			return;
		end
		w = eff_dim(reg_val[REG_IMAGE_WIDTH], DEF_MAX_WIDTH);
		h = eff_dim(reg_val[REG_IMAGE_HEIGHT], DEF_MAX_HEIGHT);
		pt = (reg_val[REG_PAD_ROWS_TOP] > 2) ? 2 : reg_val[REG_PAD_ROWS_TOP];
		pl = (reg_val[REG_PAD_COLS_LEFT] > 2) ? 2 : reg_val[REG_PAD_COLS_LEFT];
		s = reg_val[REG_STRIDE_TWO] ? 2 : 1;
		rw = eff_dim(reg_val[REG_RESULT_WIDTH], DEF_MAX_WIDTH);
		rh = eff_dim(reg_val[REG_RESULT_HEIGHT], DEF_MAX_HEIGHT);
		r = cur_row;
		c = cur_col;

		// The window slides left by one column; the new column is the two line
		// banks at this column plus the incoming pixel, which replaces the older bank.
		cur = (r & 1) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH);
		prv = ((r + 1) & 1) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH);
		for (int k = 0; k < 3; k++) begin
			win_mirror[k * 3] = win_mirror[k * 3 + 1];
			win_mirror[k * 3 + 1] = win_mirror[k * 3 + 2];
		end
		win_mirror[2] = line_mirror[cur];
		win_mirror[5] = line_mirror[prv];
		win_mirror[8] = it.pixel;
		line_mirror[cur] = it.pixel;

		nr = axis_windows(r, h, pt, s, rh, rows, rorg);
		nc = axis_windows(c, w, pl, s, rw, cols, corg);
		first = pending_sums.size();
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				acc = 0;
				for (int ky = 0; ky < 3; ky++) begin
					for (int kx = 0; kx < 3; kx++) begin
						y = rorg[i] + ky;
						x = corg[j] + kx;
						wr = y - (r - 2);
						wc = x - (c - 2);
						// Taps in the padding, or stale ones from an earlier row, are zero.
						if (y < 0 || y >= h || x < 0 || x >= w) begin
							continue;
						end
						if (wr < 0 || wr > 2 || wc < 0 || wc > 2) begin
							continue;
						end
						acc += longint'(coef_mirror[ky * 3 + kx]) *
							longint'(win_mirror[wr * 3 + wc]);
					end
				end
				res.window_sum = acc[34:0];
				res.out_row = rows[i][9:0];
				res.out_col = cols[j][9:0];
				res.last = 1'b0;
				pending_sums.push_back(res);
			end
		end
		if (pending_sums.size() > first) begin
			pending_sums[pending_sums.size() - 1].last = 1'b1;
		end

		if (c + 1 >= w) begin
			cur_col = 0;
			cur_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			cur_col = c + 1;
		end
	endtask

	// Offers one item, with random idle cycles ahead of it, and holds it until the
	// transaction completes. Valid is left high so that back-to-back items need no
	// second assignment within one time step.
	task automatic send_item(input item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_sums(it);
	endtask

	task automatic send_coef(input int index, input int value);
		item_t it;
		it = '0;
		it.func = FUNC_COEF;
		it.coef_index = index[3:0];
		it.coef_value = value[15:0];
		it.pixel = 16'($urandom);
		send_item(it);
	endtask

	task automatic send_pixel(input int value);
		item_t it;
		it = '0;
		it.func = FUNC_PIXEL;
		it.coef_index = 4'($urandom);
		it.coef_value = 16'($urandom);
		it.pixel = value[15:0];
		send_item(it);
	endtask

	// Drops valid, waits until every expected sum has been taken, then lets the
	// block finish any item that produced nothing.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Must only be called with the block idle. Any write to a real register
	// restarts the plane at row zero, column zero.
	task automatic write_reg(input logic [2:0] index, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[10:0];
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index != REG_NONE) begin
			reg_val[index] = value & 11'h7ff;
			cur_row = 0;
			cur_col = 0;
		end
		@(posedge clk);
	endtask

	task automatic set_plane(input int w, input int h, input int pt, input int pl,
			input int s2, input int rw, input int rh);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_PAD_ROWS_TOP, pt);
		write_reg(REG_PAD_COLS_LEFT, pl);
		write_reg(REG_STRIDE_TWO, s2);
		write_reg(REG_RESULT_WIDTH, rw);
		write_reg(REG_RESULT_HEIGHT, rh);
	endtask

	function automatic int rand_word();
		case ($urandom_range(7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	// All nine taps with values that include the extremes and zero, plus loads to
	// indexes past the last tap, which the block must drop without touching any coefficient.
	task automatic test_coefficient_load();
		send_coef(0, 32767);
		send_coef(1, -32768);
		send_coef(2, 16384);
		send_coef(3, -1);
		send_coef(4, 32767);
		send_coef(5, 0);
		send_coef(6, -16384);
		send_coef(7, 1);
		send_coef(8, -32768);
		send_coef(9, 12345);
		send_coef(15, -32768);
	endtask

	// A 3x3 plane with one pad above and one to the left, extreme pixels; every pixel
	// outside row zero and column zero closes a window, and the bottom-right corner pixel closes four.
	task automatic test_small_plane();
		int px [9];
		px = '{32767, -32768, 32767, -32768, 32767, -1, 256, -256, 32767};
		settle();
		set_plane(3, 3, 1, 1, 0, 3, 3);
		foreach (px[i]) send_pixel(px[i]);
	endtask

	// Zero and oversized dimensions clamp to one and to the maximum, a pad of
	// three counts as two, and a write to an unused index changes nothing. A
	// one-pixel plane with two pads above and to the left closes all nine windows at once.
	task automatic test_extreme_settings();
		settle();
		set_plane(0, 0, 3, 3, 0, 2047, 2047);
		write_reg(REG_NONE, 11'h7ff);
		send_pixel(-32768);
		send_pixel(32767);
		settle();
		set_plane(2047, 2047, 2, 2, 1, 1024, 1024);
		repeat (3) send_pixel(rand_word());
		settle();
		set_plane(1024, 1, 0, 0, 1, 0, 1);
		repeat (3) send_pixel(rand_word());
	endtask

	// Well-formed planes of random size and content, with an occasional stray
	// coefficient load mixed into the pixel stream.
	task automatic test_random_planes(input int idle_pct, input int stall_pct,
			input int pixel_goal);
		int w, h, sent;
		sent = 0;
		while (sent < pixel_goal) begin
			settle();
			send_idle_pct = idle_pct;
			recv_stall_pct = stall_pct;
			w = $urandom_range(1, 7);
			h = $urandom_range(1, 6);
			set_plane(w, h, $urandom_range(3), $urandom_range(3), $urandom_range(1),
				($urandom_range(5) == 0) ? $urandom_range(2047) : $urandom_range(1, 6),
				($urandom_range(5) == 0) ? $urandom_range(2047) : $urandom_range(1, 6));
			for (int t = 0; t < TAPS; t++) begin
				send_coef(t, rand_word());
			end
			for (int i = 0; i < w * h; i++) begin
				if ($urandom_range(9) == 0) begin
					send_coef($urandom_range(15), rand_word());
				end
				send_pixel(rand_word());
				sent++;
			end
		end
	endtask

	// Receiver side: stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// Each result transaction is compared with the oldest expected sum.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected result row %0d col %0d", out_data.out_row,
					out_data.out_col);
				failures++;
			end else begin
				want = pending_sums.pop_front();
				if (out_data.window_sum !== want.window_sum) begin
					$error("window_sum expected %0d got %0d", want.window_sum,
						out_data.window_sum);
					failures++;
				end
				if (out_data.out_row !== want.out_row) begin
					$error("out_row expected %0d got %0d", want.out_row, out_data.out_row);
					failures++;
				end
				if (out_data.out_col !== want.out_col) begin
					$error("out_col expected %0d got %0d", want.out_col, out_data.out_col);
					failures++;
				end
				if (out_data.last !== want.last) begin
					$error("last expected %0d got %0d", want.last, out_data.last);
					failures++;
				end
			end
		end
	end

	// Watchdog: any transaction on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		mirror_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_coefficient_load();
		test_small_plane();
		test_extreme_settings();
		test_random_planes(0, 0, 16);
		test_random_planes(74, 0, 16);
		test_random_planes(0, 74, 16);
		test_random_planes(16, 16, 16);

		settle();
		if (pending_sums.size() != 0) begin
			$error("%0d expected results never arrived", pending_sums.size());
			failures++;
		end
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
